[hdl/encoder_period_speed_regulator_macros.svh]
// ----------------------------------------------------------------------------
// Encoder period speed regulator assertion macros
// Shared assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ENCODER_PERIOD_SPEED_REGULATOR_MACROS_SVH
`define ENCODER_PERIOD_SPEED_REGULATOR_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define EPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("eps assertion failed");
// Same-cycle implication checked at every clock edge outside reset.
`define EPS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("eps implication failed");
`else
`define EPS_ASSERT(lbl, prop)
`define EPS_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

[hdl/eps_pkg.sv]
// ----------------------------------------------------------------------------
// Encoder period speed regulator package
// Payload types, register codes, widths and the divider digit table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package eps_pkg;

  localparam int unsigned NumCh     = 2;
  localparam int unsigned CountW    = 16;
  localparam int unsigned PeriodW   = 32;
  localparam int unsigned LevelW    = 16;
  localparam int unsigned TrackW    = 34;
  localparam int unsigned TotW      = 35;
  localparam int unsigned EdgeW     = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  localparam int unsigned EdgesPerUpdateDef = 6;
  localparam logic [PeriodW-1:0] TargetRst = PeriodW'(65000);
  localparam logic [LevelW-1:0]  PwmMaxRst = LevelW'(800);

  localparam logic signed [TrackW-1:0] TrackMax = {1'b0, {(TrackW-1){1'b1}}};
  localparam logic signed [TrackW-1:0] OvfStep  = TrackW'(65536);
  localparam logic signed [TrackW-1:0] OvfLimit = TrackMax - OvfStep;

  // Divider: radix-16 long division by a small constant, three digits per stage.
  localparam int unsigned DigitW       = 4;
  localparam int unsigned RemW         = 3;
  localparam int unsigned EntryW       = DigitW + RemW;
  localparam int unsigned DigitTblDep  = 2 ** EntryW;
  localparam int unsigned DigitTblW    = DigitTblDep * EntryW;
  localparam int unsigned StageDigits  = 3;
  localparam int unsigned StageBits    = StageDigits * DigitW;
  localparam int unsigned DivStages    = 3;
  localparam int unsigned WorkW        = DivStages * StageBits;

  typedef enum logic {
    REQ_OVERFLOW = 1'b0,
    REQ_CAPTURE  = 1'b1
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_PERIOD = 2'd0,
    REG_PWM_MAX       = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic              req_type;
    logic              channel;
    logic [CountW-1:0] capture_count;
  } in_t;

  typedef struct packed {
    logic               out_channel;
    logic [PeriodW-1:0] period;
    logic               updated;
    logic [PeriodW-1:0] average_period;
    logic [LevelW-1:0]  pwm_level;
  } out_t;

  // Result on its way through the divider; work holds the dividend digits
  // still to be divided above the quotient digits already produced.
  typedef struct packed {
    out_t             res;
    logic [WorkW-1:0] work;
    logic [RemW-1:0]  rem;
  } div_t;

  // Entry {rem, digit} holds {quotient digit, new remainder} for divisor n.
  // Built at elaboration by repeated subtraction.
  function automatic logic [DigitTblW-1:0] digit_table(input int unsigned n);
    logic [DigitTblW-1:0] tbl;
    int unsigned i;
    int unsigned k;
    int unsigned q;
    int unsigned r;
    tbl = '0;
    for (i = 0; i < DigitTblDep; i++) begin
      r = i;
      q = 0;
      for (k = 0; k < 2 ** DigitW; k++) begin
        if (r >= n) begin
          r = r - n;
          q = q + 1;
        end
      end
      tbl[i*EntryW +: EntryW] = {DigitW'(q), RemW'(r)};
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

[hdl/eps_div_stage.sv]
// ----------------------------------------------------------------------------
// Divider stage
// Divides the next three radix-16 digits of the window total by the edge count.
// ----------------------------------------------------------------------------
`default_nettype none

module eps_div_stage #(
  parameter int unsigned EDGES_PER_UPDATE = eps_pkg::EdgesPerUpdateDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        up_valid_i,
  output logic             up_ready_o,
  input  wire eps_pkg::div_t up_data_i,
  output logic             dn_valid_o,
  input  wire logic        dn_ready_i,
  output eps_pkg::div_t    dn_data_o
);

  localparam logic [eps_pkg::DigitTblW-1:0] DigitTbl =
    eps_pkg::digit_table(EDGES_PER_UPDATE);

  logic [eps_pkg::EntryW-1:0]    digit_lut [eps_pkg::DigitTblDep];
  logic                          vld_q;
  eps_pkg::div_t                 data_q;
  eps_pkg::div_t                 data_d;
  logic [eps_pkg::StageBits-1:0] hi;
  logic [eps_pkg::StageBits-1:0] quo;
  logic [eps_pkg::RemW-1:0]      rem;
  logic [eps_pkg::EntryW-1:0]    entry;

  always_comb begin
    for (int i = 0; i < eps_pkg::DigitTblDep; i++) begin
      digit_lut[i] = DigitTbl[i*eps_pkg::EntryW +: eps_pkg::EntryW];
    end
  end

  // Long division, most significant digit first; the processed digits leave
  // the top of the work word and the quotient digits enter at the bottom.
  always_comb begin
    hi    = up_data_i.work[eps_pkg::WorkW-1 -: eps_pkg::StageBits];
    rem   = up_data_i.rem;
    quo   = '0;
    entry = '0;
    for (int j = 0; j < eps_pkg::StageDigits; j++) begin
      entry = digit_lut[{rem, hi[eps_pkg::StageBits-1-j*eps_pkg::DigitW -: eps_pkg::DigitW]}];
      quo[eps_pkg::StageBits-1-j*eps_pkg::DigitW -: eps_pkg::DigitW] =
        entry[eps_pkg::EntryW-1 -: eps_pkg::DigitW];
      rem = entry[eps_pkg::RemW-1:0];
    end
    data_d      = up_data_i;
    data_d.work = {up_data_i.work[eps_pkg::WorkW-eps_pkg::StageBits-1:0], quo};
    data_d.rem  = rem;
  end

  assign up_ready_o = !vld_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (up_ready_o) begin
      vld_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= data_d;
    end
  end

  assign dn_valid_o = vld_q;
  assign dn_data_o  = data_q;

endmodule

`default_nettype wire

[hdl/eps_core.sv]
// ----------------------------------------------------------------------------
// Regulator core
// Input register, per-channel period tracking, windowing and PWM stepping.
// ----------------------------------------------------------------------------
`default_nettype none
`include "encoder_period_speed_regulator_macros.svh"

module eps_core #(
  parameter int unsigned EDGES_PER_UPDATE = eps_pkg::EdgesPerUpdateDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire eps_pkg::in_t                   in_data_i,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [eps_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [eps_pkg::CfgDataW-1:0]   cfg_data_i,
  output logic                                res_valid_o,
  input  wire logic                           res_ready_i,
  output eps_pkg::div_t                       res_data_o
);

  localparam logic [eps_pkg::TotW-1:0]   TnRst =
    eps_pkg::TotW'(eps_pkg::TargetRst) * eps_pkg::TotW'(EDGES_PER_UPDATE);
  localparam logic [eps_pkg::TotW:0]     TupRst =
    (eps_pkg::TotW+1)'(TnRst) + (eps_pkg::TotW+1)'(EDGES_PER_UPDATE);
  localparam logic [eps_pkg::EdgeW-1:0]  EdgeLast = eps_pkg::EdgeW'(EDGES_PER_UPDATE);

  // Configuration: the setpoint is kept pre-scaled by the window length so
  // that the floor average never has to be formed in the feedback loop.
  logic [eps_pkg::TotW-1:0]   tn_q;
  logic [eps_pkg::TotW:0]     tup_q;
  logic [eps_pkg::LevelW-1:0] pwm_max_q;
  logic [eps_pkg::TotW-1:0]   tn_d;

  logic                       in_vld_q;
  eps_pkg::in_t               in_q;
  logic                       res_vld_q;
  eps_pkg::div_t              res_q;
  eps_pkg::div_t              res_d;

  logic signed [eps_pkg::TrackW-1:0] trk_q [eps_pkg::NumCh];
  logic [eps_pkg::TotW-1:0]          win_q [eps_pkg::NumCh];
  logic [eps_pkg::EdgeW-1:0]         edge_q [eps_pkg::NumCh];
  logic [eps_pkg::LevelW-1:0]        drv_q [eps_pkg::NumCh];
  logic signed [eps_pkg::TrackW-1:0] trk_ovf [eps_pkg::NumCh];

  logic                         is_cap;
  logic                         res_free;
  logic                         consume;
  logic                         ch;
  logic [eps_pkg::TrackW-1:0]   trk_sel;
  logic [eps_pkg::TotW-1:0]     sum;
  logic [eps_pkg::PeriodW-1:0]  per;
  logic [eps_pkg::TotW-1:0]     tot_new;
  logic [eps_pkg::EdgeW-1:0]    edge_new;
  logic                         done;
  logic                         step_up;
  logic                         step_dn;
  logic [eps_pkg::LevelW-1:0]   lvl;
  logic [eps_pkg::LevelW-1:0]   lvl_new;
  logic [eps_pkg::TrackW-1:0]   trk_cap;

  assign cfg_ready_o = 1'b1;
  assign tn_d = eps_pkg::TotW'(cfg_data_i) * eps_pkg::TotW'(EDGES_PER_UPDATE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tn_q      <= TnRst;
      tup_q     <= TupRst;
      pwm_max_q <= eps_pkg::PwmMaxRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (eps_pkg::cfg_idx_e'(cfg_index_i))
        eps_pkg::REG_TARGET_PERIOD: begin
          tn_q  <= tn_d;
          tup_q <= (eps_pkg::TotW+1)'(tn_d) + (eps_pkg::TotW+1)'(EDGES_PER_UPDATE);
        end
        eps_pkg::REG_PWM_MAX: begin
          pwm_max_q <= cfg_data_i[eps_pkg::LevelW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake: overflow events retire here, captures need room downstream.
  assign is_cap     = (in_q.req_type == eps_pkg::REQ_CAPTURE);
  assign res_free   = !res_vld_q || res_ready_i;
  assign consume    = in_vld_q && (!is_cap || res_free);
  assign in_ready_o = !in_vld_q || consume;

  always_comb begin
    for (int c = 0; c < eps_pkg::NumCh; c++) begin
      trk_ovf[c] = (trk_q[c] > eps_pkg::OvfLimit) ? eps_pkg::TrackMax
                                                   : trk_q[c] + eps_pkg::OvfStep;
    end
  end

  always_comb begin
    ch       = in_q.channel;
    trk_sel  = trk_q[ch];
    sum      = {trk_sel[eps_pkg::TrackW-1], trk_sel} + eps_pkg::TotW'(in_q.capture_count);
    trk_cap  = eps_pkg::TrackW'(0) - eps_pkg::TrackW'(in_q.capture_count);
    // Negative periods read as zero, long ones clamp to the 32-bit maximum.
    priority if (sum[eps_pkg::TotW-1]) begin
      per = '0;
    end else if (|sum[eps_pkg::TotW-2:eps_pkg::PeriodW]) begin
      per = '1;
    end else begin
      per = sum[eps_pkg::PeriodW-1:0];
    end
    tot_new  = win_q[ch] + eps_pkg::TotW'(per);
    edge_new = edge_q[ch] + eps_pkg::EdgeW'(1);
    done     = (edge_new == EdgeLast);
    // floor(total / N) > target  <=>  total >= N * target + N.
    step_up  = done && ({1'b0, tot_new} >= tup_q);
    step_dn  = done && (tot_new < tn_q);
    lvl      = drv_q[ch];
    lvl_new  = lvl;
    if (step_up) begin
      lvl_new = (lvl >= pwm_max_q) ? pwm_max_q : lvl + eps_pkg::LevelW'(1);
    end else if (step_dn && (lvl != '0)) begin
      lvl_new = lvl - eps_pkg::LevelW'(1);
    end
    res_d.res.out_channel    = ch;
    res_d.res.period         = per;
    res_d.res.updated        = done;
    res_d.res.average_period = '0;
    res_d.res.pwm_level      = lvl_new;
    res_d.work               = done ? eps_pkg::WorkW'(tot_new) : '0;
    res_d.rem                = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      for (int c = 0; c < eps_pkg::NumCh; c++) begin
        trk_q[c]  <= '0;
        win_q[c]  <= '0;
        edge_q[c] <= '0;
        drv_q[c]  <= '0;
      end
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (res_free) begin
        res_vld_q <= consume && is_cap;
      end
      if (consume) begin
        if (is_cap) begin
          trk_q[ch]  <= trk_cap;
          win_q[ch]  <= done ? '0 : tot_new;
          edge_q[ch] <= done ? '0 : edge_new;
          drv_q[ch]  <= lvl_new;
        end else begin
          for (int c = 0; c < eps_pkg::NumCh; c++) begin
            trk_q[c] <= trk_ovf[c];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (consume && is_cap) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_vld_q;
  assign res_data_o  = res_q;

  `EPS_ASSERT_IMPLY(a_ready_low_needs_item, !in_ready_o, in_vld_q)

  for (genvar g = 0; g < eps_pkg::NumCh; g++) begin : g_chk
    `EPS_ASSERT(a_edge_below_window, edge_q[g] < EdgeLast)
    `EPS_ASSERT_IMPLY(a_empty_window_zero, edge_q[g] == '0, win_q[g] == '0)
    `EPS_ASSERT(a_level_single_step, (drv_q[g] == $past(drv_q[g])) || (drv_q[g] == $past(drv_q[g]) + 16'd1) || (drv_q[g] == $past(drv_q[g]) - 16'd1) || (drv_q[g] == pwm_max_q))
  end

endmodule

`default_nettype wire

[hdl/encoder_period_speed_regulator.sv]
// ----------------------------------------------------------------------------
// Encoder period speed regulator
// Two-channel wheel speed regulator fed by timer overflow and capture events.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                                  Direction  Moves
//   in       in_valid_i / in_ready_o / in_data_i      to block   timer event
//   out      out_valid_o / out_ready_i / out_data_o   from block one result per capture
//   cfg      cfg_valid_i / cfg_ready_o / cfg_index_i  to block   register write
//            / cfg_data_i
//
// One input transfer can be taken in every cycle, except while a capture is
// held in the input register by an output stall. A capture result passes
// through the input register, the update register and the first two
// divider stages in that order, and is presented from the third divider stage.
// Reset loads the register defaults and clears all channel state at once;
// there is no clearing pass. Every stage moves on whenever the one after it
// is empty or draining, so bubbles close up during output stalls.
//
// An overflow event adds 65536 to both period trackers (saturating) and
// produces no result. A capture measures the period as tracker plus count,
// clamps it to 32 bits, accumulates it and reloads the tracker with minus the
// count. Every EDGES_PER_UPDATE captures on a channel, the window total is
// compared with the setpoint scaled by the window length, which is the same
// as comparing the floor average with the setpoint, and the PWM level steps
// by one toward the setpoint, held within zero and pwm_max. The floor
// average itself is only reported, so its division sits after the feedback
// loop in a radix-16 long-division pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_period_speed_regulator #(
  parameter int unsigned EDGES_PER_UPDATE = eps_pkg::EdgesPerUpdateDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire eps_pkg::in_t                 in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output eps_pkg::out_t                     out_data_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [eps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [eps_pkg::CfgDataW-1:0] cfg_data_i
);

  // Stage 0 is the update stage output; the last entry feeds the port.
  logic          st_vld  [eps_pkg::DivStages+1];
  logic          st_rdy  [eps_pkg::DivStages+1];
  eps_pkg::div_t st_data [eps_pkg::DivStages+1];

  eps_core #(
    .EDGES_PER_UPDATE (EDGES_PER_UPDATE)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (st_vld[0]),
    .res_ready_i (st_rdy[0]),
    .res_data_o  (st_data[0])
  );

  for (genvar g = 0; g < eps_pkg::DivStages; g++) begin : g_div
    eps_div_stage #(
      .EDGES_PER_UPDATE (EDGES_PER_UPDATE)
    ) u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (st_vld[g]),
      .up_ready_o (st_rdy[g]),
      .up_data_i  (st_data[g]),
      .dn_valid_o (st_vld[g+1]),
      .dn_ready_i (st_rdy[g+1]),
      .dn_data_o  (st_data[g+1])
    );
  end

  assign st_rdy[eps_pkg::DivStages] = out_ready_i;
  assign out_valid_o = st_vld[eps_pkg::DivStages];

  // After the last stage the work word holds the quotient. The sum of a
  // window of 32-bit periods divided by its length always fits 32 bits, and
  // a capture that closes no window carries a zero dividend.
  always_comb begin
    out_data_o                = st_data[eps_pkg::DivStages].res;
    out_data_o.average_period = st_data[eps_pkg::DivStages].work[eps_pkg::PeriodW-1:0];
  end

endmodule

`default_nettype wire
